// ===== hdl/spvc_pkg.sv =====
// Shared constants, codes and types for the simple polygon vertex checker.
`default_nettype none

package spvc_pkg;

	// Sizes
	localparam int MAX_POINTS         = 16;
	localparam int GRID_COLS          = 64;
	localparam int GRID_ROWS          = 64;
	localparam int MIN_CLOSE_VERTICES = 3;

	localparam int COORD_W  = 6;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 3;
	localparam int STAGE_W  = 2;
	localparam int IDX_W    = $clog2(MAX_POINTS);
	localparam int CNT_W    = $clog2(MAX_POINTS + 1);

	// Command codes; the unused code behaves as a probe
	localparam logic [CMD_W-1:0] CMD_PROBE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PLACE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_PROBED   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_CROSSING = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REPEAT   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_COMPLETE = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FAILED   = 3'd5;
	localparam logic [STATUS_W-1:0] ST_INACTIVE = 3'd6;

	// Build stage codes
	localparam logic [STAGE_W-1:0] STG_PENDING  = 2'd0;
	localparam logic [STAGE_W-1:0] STG_COMPLETE = 2'd1;
	localparam logic [STAGE_W-1:0] STG_FAILED   = 2'd2;

	// One grid point
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} point_t;

	// Position of the edge under test within the stored chain
	typedef struct packed {
		logic first;
		logic last;
	} edge_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/spvc_edge_test.sv =====
// Segment test unit: checks the candidate edge against one stored edge.
`default_nettype none

module spvc_edge_test (
	input  spvc_pkg::point_t    p,
	input  spvc_pkg::point_t    q,
	input  spvc_pkg::point_t    s,
	input  spvc_pkg::point_t    t,
	input  spvc_pkg::edge_ctl_t ctl,
	output logic                hit
);
	import spvc_pkg::*;

	localparam int DIF_W = COORD_W + 1;
	localparam int PRD_W = 2 * DIF_W;
	localparam int CRS_W = PRD_W + 1;

	typedef logic signed [DIF_W-1:0] dif_t;
	typedef logic signed [CRS_W-1:0] crs_t;

	function automatic dif_t diff(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b);
		dif_t ea;
		dif_t eb;
		ea = $signed({1'b0, a});
		eb = $signed({1'b0, b});
		return ea - eb;
	endfunction

	function automatic crs_t cross2(input dif_t ax, input dif_t ay, input dif_t bx,
			input dif_t by);
		crs_t l;
		crs_t r;
		l = CRS_W'(ax * by);
		r = CRS_W'(ay * bx);
		return l - r;
	endfunction

	// Sign as {negative, zero}, so two values share a sign when codes match
	function automatic logic [1:0] sgn(input crs_t v);
		return {v < 0, v == 0};
	endfunction

	dif_t dx, dy, ex, ey;
	crs_t c_ds, c_dt, c_ep, c_eq, c_de, dot_de;
	logic straddle_cand, straddle_edge, skip_first;

	assign dx = diff(q.x, p.x);
	assign dy = diff(q.y, p.y);
	assign ex = diff(t.x, s.x);
	assign ey = diff(t.y, s.y);

	// Orientation of each end against the other segment
	assign c_ds = cross2(dx, dy, diff(s.x, p.x), diff(s.y, p.y));
	assign c_dt = cross2(dx, dy, diff(t.x, p.x), diff(t.y, p.y));
	assign c_ep = cross2(ex, ey, diff(p.x, s.x), diff(p.y, s.y));
	assign c_eq = cross2(ex, ey, diff(q.x, s.x), diff(q.y, s.y));

	// Newest edge: collide only when doubling straight back
	assign c_de   = cross2(dx, dy, ex, ey);
	assign dot_de = CRS_W'(dx * ex) + CRS_W'(dy * ey);

	assign straddle_cand = sgn(c_ds) != sgn(c_dt);
	assign straddle_edge = sgn(c_ep) != sgn(c_eq);
	assign skip_first    = ctl.first && (q == s);

	always_comb begin
		if (ctl.last) begin
			hit = (c_de == 0) && (dot_de < 0);
		end else if (skip_first) begin
			hit = 1'b0;
		end else begin
			hit = straddle_cand && straddle_edge;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/simple_polygon_vertex_checker.sv =====
// Top level of the simple polygon vertex checker: sequencer, vertex store, result register.
`default_nettype none

// Each input word probes, places or restarts against a polygon held in a 16-entry
// vertex store. The candidate edge is checked against the stored edges one edge a
// cycle through a single segment test unit: the newest vertex is read, then each
// stored vertex in turn, and a decision state follows; a restart or a word against
// an empty polygon goes straight to the decision. in_stall is high while a word is
// being worked on. Every input word gives exactly one result word, held in an output
// register, so the next input word is taken while an earlier result still waits on
// out_stall.
module simple_polygon_vertex_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [spvc_pkg::CMD_W-1:0]    command,
	input  logic [spvc_pkg::COORD_W-1:0]  cell_col,
	input  logic [spvc_pkg::COORD_W-1:0]  cell_row,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [spvc_pkg::STATUS_W-1:0] status,
	output logic                          crossing,
	output logic [spvc_pkg::CNT_W-1:0]    vertex_count,
	output logic [spvc_pkg::STAGE_W-1:0]  stage
);
	import spvc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RDP   = 4'b0010,
		S_SWEEP = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	state_t               state_q;
	logic [CMD_W-1:0]     cmd_q;
	point_t               q_q, p_q, v0_q, s_q, rd_q;
	logic [IDX_W-1:0]     idx_q, rd_addr;
	logic                 hit_q;
	logic [CNT_W-1:0]     count_q, count_m1;
	logic [STAGE_W-1:0]   stage_q;
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic                 crossing_q;
	logic [CNT_W-1:0]     vcount_q;
	logic [STAGE_W-1:0]   vstage_q;

	logic [COORD_W-1:0]   vx_mem_q [MAX_POINTS];
	logic [COORD_W-1:0]   vy_mem_q [MAX_POINTS];

	logic                 in_acc, fin_go, wr_en, edge_hit, on_first, is_repeat;
	point_t               cand;
	edge_ctl_t            ectl;
	logic [CNT_W-1:0]     nxt_count;
	logic [STAGE_W-1:0]   nxt_stage;
	logic [STATUS_W-1:0]  nxt_status;

	assign in_stall  = state_q != S_IDLE;
	assign in_acc    = in_valid && !in_stall;
	assign fin_go    = (state_q == S_FIN) && !(out_valid_q && out_stall);
	assign count_m1  = count_q - CNT_W'(1);

	// Saturate the cell to the grid
	always_comb begin
		cand.x = cell_col;
		cand.y = cell_row;
		if (cell_col > COORD_W'(GRID_COLS - 1)) begin
			cand.x = COORD_W'(GRID_COLS - 1);
		end
		if (cell_row > COORD_W'(GRID_ROWS - 1)) begin
			cand.y = COORD_W'(GRID_ROWS - 1);
		end
	end

	// Pick the store address for the next cycle
	always_comb begin
		unique case (state_q)
			S_IDLE:  rd_addr = count_m1[IDX_W-1:0];
			S_SWEEP: rd_addr = idx_q + IDX_W'(1);
			default: rd_addr = '0;
		endcase
	end

	// Vertex store: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			vx_mem_q[count_q[IDX_W-1:0]] <= q_q.x;
			vy_mem_q[count_q[IDX_W-1:0]] <= q_q.y;
		end
		rd_q.x <= vx_mem_q[rd_addr];
		rd_q.y <= vy_mem_q[rd_addr];
	end

	// Shared segment test, one stored edge per cycle
	assign ectl.first = idx_q == IDX_W'(1);
	assign ectl.last  = CNT_W'(idx_q) == count_m1;

	spvc_edge_test u_edge (
		.p   (p_q),
		.q   (q_q),
		.s   (s_q),
		.t   (rd_q),
		.ctl (ectl),
		.hit (edge_hit)
	);

	// Decide the outcome of the word
	assign is_repeat = (count_q != '0) && (p_q == q_q);
	assign on_first  = (count_q != '0) && (v0_q == q_q);

	always_comb begin
		nxt_count  = count_q;
		nxt_stage  = stage_q;
		nxt_status = ST_PROBED;
		wr_en      = 1'b0;
		if (cmd_q == CMD_RESTART) begin
			nxt_count  = '0;
			nxt_stage  = STG_PENDING;
			nxt_status = ST_INACTIVE;
		end else if (cmd_q == CMD_PLACE) begin
			if (stage_q != STG_PENDING) begin
				nxt_status = ST_INACTIVE;
			end else if (hit_q) begin
				nxt_status = ST_CROSSING;
			end else if (is_repeat) begin
				nxt_status = ST_REPEAT;
			end else if (count_q >= CNT_W'(MAX_POINTS)) begin
				nxt_stage  = on_first ? STG_COMPLETE : STG_FAILED;
				nxt_status = on_first ? ST_COMPLETE : ST_FAILED;
			end else if (count_q >= CNT_W'(MIN_CLOSE_VERTICES) && on_first) begin
				nxt_stage  = STG_COMPLETE;
				nxt_status = ST_COMPLETE;
			end else begin
				nxt_count  = count_q + CNT_W'(1);
				nxt_status = ST_ADDED;
				wr_en      = fin_go;
			end
		end
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			stage_q     <= STG_PENDING;
			out_valid_q <= 1'b0;
		end else begin
			// Raise the result on a decision, drop it once taken
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (command == CMD_RESTART || count_q == '0) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_RDP;
						end
					end
				end
				S_RDP: begin
					state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					if (CNT_W'(idx_q) == count_m1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						count_q     <= nxt_count;
						stage_q     <= nxt_stage;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of the sweep
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					cmd_q <= command;
					q_q   <= cand;
					hit_q <= 1'b0;
					idx_q <= '0;
				end
			end
			S_RDP: begin
				p_q <= rd_q;
			end
			S_SWEEP: begin
				s_q   <= rd_q;
				idx_q <= idx_q + IDX_W'(1);
				if (idx_q == '0) begin
					v0_q <= rd_q;
				end else begin
					hit_q <= hit_q | edge_hit;
				end
			end
			S_FIN: begin
				if (fin_go) begin
					status_q   <= nxt_status;
					crossing_q <= hit_q;
					vcount_q   <= nxt_count;
					vstage_q   <= nxt_stage;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign crossing     = crossing_q;
	assign vertex_count = vcount_q;
	assign stage        = vstage_q;

endmodule

`default_nettype wire

// ===== hdl/spvc_checker.sv =====
// Port-level assertions for the simple polygon vertex checker, bound to the top level.
`default_nettype none

module spvc_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [spvc_pkg::STATUS_W-1:0] status,
	input  logic                          crossing,
	input  logic [spvc_pkg::CNT_W-1:0]    vertex_count,
	input  logic [spvc_pkg::STAGE_W-1:0]  stage
);
	import spvc_pkg::*;

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(vertex_count))
		else $error("stalled result word changed");

	// Block the input in the cycle after taking a word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken on back-to-back cycles");

	// Never report more vertices than the store holds
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> vertex_count <= CNT_W'(MAX_POINTS))
		else $error("vertex count beyond capacity");

	// An added vertex leaves the polygon pending, with no crossing
	a_added: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ADDED |-> stage == STG_PENDING && !crossing
			&& vertex_count != '0)
		else $error("inconsistent added word");

	// A crossing status always reports a crossing, a completion always the completed stage
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_CROSSING || status == ST_COMPLETE) |->
			(status == ST_CROSSING && crossing) || (status == ST_COMPLETE
			&& stage == STG_COMPLETE))
		else $error("inconsistent reject or completion word");

endmodule

bind simple_polygon_vertex_checker spvc_checker u_spvc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.crossing     (crossing),
	.vertex_count (vertex_count),
	.stage        (stage)
);

`default_nettype wire
